// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold on every clock edge out of reset.
`define CAU_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define CAU_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/cau_pkg.sv =====
// Types, codes and helper functions of the complex arithmetic unit.
`timescale 1ns / 1ps
package cau_pkg;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_e;

    // Quotient bits produced by the divider, one per divider stage
    localparam int DIV_BITS = 16;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [15:0] a_re;
        logic signed [15:0] a_im;
        logic signed [15:0] b_re;
        logic signed [15:0] b_im;
    } cmd_t;

    typedef struct packed {
        logic signed [15:0] res_re;
        logic signed [15:0] res_im;
        logic               saturated;
        logic               div_zero;
    } rsp_t;

    // Classified item handed from front to back
    typedef struct packed {
        op_e                op;
        logic signed [16:0] alu_re;
        logic signed [16:0] alu_im;
        logic signed [31:0] p_rr;
        logic signed [31:0] p_ii;
        logic signed [31:0] p_ri;
        logic signed [31:0] p_ir;
        logic [30:0]        sq_re;
        logic [30:0]        sq_im;
    } work_t;

    // Clip to Q8.8; MSB of the result is the clip flag
    function automatic logic [16:0] sat16(input logic signed [32:0] v);
        logic [16:0] r;
        if (v > 33'sd32767) begin
            r = {1'b1, 16'h7fff};
        end else if (v < -33'sd32768) begin
            r = {1'b1, 16'h8000};
        end else begin
            r = {1'b0, v[15:0]};
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/cau_fifo.sv =====
// Small flop-based queue used between front and back and on the result side.
`timescale 1ns / 1ps
module cau_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rd_data_reg;
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             do_wr, do_rd;

    assign full    = (cnt_reg == CW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = rd_data_reg;

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Storage; the next head beat is read into a register, bypassing a write
    // into an otherwise empty queue
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
        if (do_wr && (wr_ptr_reg == rd_ptr_next))
        begin
            rd_data_reg <= wr_data;
        end else
        begin
            rd_data_reg <= mem[rd_ptr_next];
        end
    end
endmodule

// ===== rtl/core/cau_front.sv =====
// Front end: takes a beat, forms sums and partial products, hands work on.
`timescale 1ns / 1ps
module cau_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  cau_pkg::cmd_t       cmd,
    output logic                full,
    output logic                wr_en,
    output cau_pkg::work_t      wr_data,
    input  logic                wr_full
);
    cau_pkg::cmd_t item_reg;
    logic          vld_reg, vld_next;
    logic          accept;

    assign full   = vld_reg && wr_full;
    assign accept = push && !full;
    assign wr_en  = vld_reg && !wr_full;

    always_comb
    begin
        vld_next = vld_reg;
        if (accept)
        begin
            vld_next = 1'b1;
        end else if (wr_en)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= cmd;
        end
    end

    // Classify and compute partial results
    logic signed [31:0] sq_re_w, sq_im_w;
    always_comb
    begin
        wr_data.op = cau_pkg::op_e'(item_reg.opcode);
        if (wr_data.op == cau_pkg::OP_SUB)
        begin
            wr_data.alu_re = 17'(item_reg.a_re) - 17'(item_reg.b_re);
            wr_data.alu_im = 17'(item_reg.a_im) - 17'(item_reg.b_im);
        end else
        begin
            wr_data.alu_re = 17'(item_reg.a_re) + 17'(item_reg.b_re);
            wr_data.alu_im = 17'(item_reg.a_im) + 17'(item_reg.b_im);
        end
        wr_data.p_rr  = 32'(item_reg.a_re) * 32'(item_reg.b_re);
        wr_data.p_ii  = 32'(item_reg.a_im) * 32'(item_reg.b_im);
        wr_data.p_ri  = 32'(item_reg.a_re) * 32'(item_reg.b_im);
        wr_data.p_ir  = 32'(item_reg.a_im) * 32'(item_reg.b_re);
        sq_re_w       = 32'(item_reg.b_re) * 32'(item_reg.b_re);
        sq_im_w       = 32'(item_reg.b_im) * 32'(item_reg.b_im);
        wr_data.sq_re = sq_re_w[30:0];
        wr_data.sq_im = sq_im_w[30:0];
    end
endmodule

// ===== rtl/core/cau_back.sv =====
// Back end: combines products, restoring divider pipeline, saturation.
`timescale 1ns / 1ps
module cau_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_vld,
    input  cau_pkg::work_t      in_work,
    output logic                out_vld,
    output cau_pkg::rsp_t       out_rsp
);
    localparam int NB = cau_pkg::DIV_BITS;

    typedef struct packed {
        cau_pkg::op_e       op;
        logic [16:0]        smp_re;
        logic [16:0]        smp_im;
        logic signed [32:0] num_re;
        logic signed [32:0] num_im;
        logic [31:0]        mag;
    } b0_t;

    typedef struct packed {
        cau_pkg::op_e op;
        logic [16:0]  smp_re;
        logic [16:0]  smp_im;
        logic [31:0]  mag;
        logic [39:0]  rem_re;
        logic [39:0]  rem_im;
        logic [NB-1:0] q_re;
        logic [NB-1:0] q_im;
        logic         neg_re;
        logic         neg_im;
        logic         ovf_re;
        logic         ovf_im;
    } div_t;

    // One restoring step on a remainder against mag shifted by sh
    function automatic logic [40:0] div_step(input logic [39:0] rem, input logic [31:0] mag,
                                             input int sh);
        logic [47:0] dv;
        logic [47:0] ext;
        logic [47:0] df;
        logic [40:0] r;
        dv  = 48'(mag) << sh;
        ext = 48'(rem);
        df  = ext - dv;
        if (ext >= dv) begin
            r = {1'b1, df[39:0]};
        end else begin
            r = {1'b0, rem};
        end
        return r;
    endfunction

    // Stage B0: add/sub/mul results, division numerators and magnitude
    b0_t  b0_reg, b0_next;
    logic b0_vld_reg;
    logic signed [32:0] mr, mi, mr_t, mi_t;
    always_comb
    begin
        mr = 33'(in_work.p_rr) - 33'(in_work.p_ii);
        mi = 33'(in_work.p_ri) + 33'(in_work.p_ir);
        mr_t = (mr + ((mr < 0) ? 33'sd255 : 33'sd0)) >>> 8;
        mi_t = (mi + ((mi < 0) ? 33'sd255 : 33'sd0)) >>> 8;
        b0_next.op = in_work.op;
        if (in_work.op == cau_pkg::OP_MUL)
        begin
            b0_next.smp_re = cau_pkg::sat16(mr_t);
            b0_next.smp_im = cau_pkg::sat16(mi_t);
        end else
        begin
            b0_next.smp_re = cau_pkg::sat16(33'(in_work.alu_re));
            b0_next.smp_im = cau_pkg::sat16(33'(in_work.alu_im));
        end
        b0_next.num_re = 33'(in_work.p_rr) + 33'(in_work.p_ii);
        b0_next.num_im = 33'(in_work.p_ir) - 33'(in_work.p_ri);
        b0_next.mag    = 32'(in_work.sq_re) + 32'(in_work.sq_im);
    end

    // Stage B1: magnitudes of numerators, overflow pre-check
    div_t st_reg [0:NB];
    logic vld_reg [0:NB];
    div_t b1_next;
    logic signed [32:0] abs_re_w, abs_im_w;
    always_comb
    begin
        abs_re_w = (b0_reg.num_re < 0) ? -b0_reg.num_re : b0_reg.num_re;
        abs_im_w = (b0_reg.num_im < 0) ? -b0_reg.num_im : b0_reg.num_im;
        b1_next.op     = b0_reg.op;
        b1_next.smp_re = b0_reg.smp_re;
        b1_next.smp_im = b0_reg.smp_im;
        b1_next.mag    = b0_reg.mag;
        b1_next.rem_re = {abs_re_w[31:0], 8'd0};
        b1_next.rem_im = {abs_im_w[31:0], 8'd0};
        b1_next.q_re   = '0;
        b1_next.q_im   = '0;
        b1_next.neg_re = (b0_reg.num_re < 0);
        b1_next.neg_im = (b0_reg.num_im < 0);
        b1_next.ovf_re = ({8'd0, abs_re_w[31:0], 8'd0} >= {b0_reg.mag, 16'd0});
        b1_next.ovf_im = ({8'd0, abs_im_w[31:0], 8'd0} >= {b0_reg.mag, 16'd0});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b0_vld_reg <= 1'b0;
            vld_reg[0] <= 1'b0;
        end else
        begin
            b0_vld_reg <= in_vld;
            vld_reg[0] <= b0_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        b0_reg    <= b0_next;
        st_reg[0] <= b1_next;
    end

    // Divider stages, one quotient bit each, MSB first
    for (genvar k = 0; k < NB; k++)
    begin : g_div
        localparam int SH = NB - 1 - k;
        div_t        nx;
        logic [40:0] sr, si;
        always_comb
        begin
            sr = div_step(st_reg[k].rem_re, st_reg[k].mag, SH);
            si = div_step(st_reg[k].rem_im, st_reg[k].mag, SH);
            nx = st_reg[k];
            nx.rem_re   = sr[39:0];
            nx.rem_im   = si[39:0];
            nx.q_re[SH] = sr[40];
            nx.q_im[SH] = si[40];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k+1] <= 1'b0;
            end else
            begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            st_reg[k+1] <= nx;
        end
    end

    // Final selection and saturation
    div_t        fin;
    logic [16:0] dre, dim;
    assign fin     = st_reg[NB];
    assign out_vld = vld_reg[NB];
    always_comb
    begin
        if (fin.ovf_re)
        begin
            dre = {1'b1, fin.neg_re ? 16'h8000 : 16'h7fff};
        end else
        begin
            dre = cau_pkg::sat16(fin.neg_re ? -33'({1'b0, fin.q_re}) : 33'({1'b0, fin.q_re}));
        end
        if (fin.ovf_im)
        begin
            dim = {1'b1, fin.neg_im ? 16'h8000 : 16'h7fff};
        end else
        begin
            dim = cau_pkg::sat16(fin.neg_im ? -33'({1'b0, fin.q_im}) : 33'({1'b0, fin.q_im}));
        end

        case (fin.op)
            cau_pkg::OP_DIV:
            begin
                if (fin.mag == '0)
                begin
                    out_rsp = '{res_re: '0, res_im: '0, saturated: 1'b0, div_zero: 1'b1};
                end else
                begin
                    out_rsp.res_re    = dre[15:0];
                    out_rsp.res_im    = dim[15:0];
                    out_rsp.saturated = dre[16] | dim[16];
                    out_rsp.div_zero  = 1'b0;
                end
            end
            default:
            begin
                out_rsp.res_re    = fin.smp_re[15:0];
                out_rsp.res_im    = fin.smp_im[15:0];
                out_rsp.saturated = fin.smp_re[16] | fin.smp_im[16];
                out_rsp.div_zero  = 1'b0;
            end
        endcase
    end
endmodule

// ===== rtl/core/complex_arith_unit.sv =====
// Complex add/sub/mul/div on Q8.8 operands: front end, work queue, back end.
//
//  channel | handshake      | payload
//  --------+----------------+---------------------------------------------
//  cmd     | push / full    | opcode, a_re, a_im, b_re, b_im (cau_pkg::cmd_t)
//  rsp     | pop / empty    | res_re, res_im, saturated, div_zero (rsp_t)
//
//  One beat per cycle sustained in both directions while the receiver keeps popping.
//  From accept to result visible a beat passes the front register, the work
//  queue, 2 setup stages and 16 divider stages (one quotient bit each).
//  The back end never stalls; it issues only while a result queue slot is free.
//  Reset is asynchronous, active low, and empties every queue and pipeline.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module complex_arith_unit #(
    parameter int MID_DEPTH = 4,
    parameter int OUT_DEPTH = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  cau_pkg::cmd_t  cmd,
    output logic           full,
    input  logic           pop,
    output cau_pkg::rsp_t  rsp,
    output logic           empty
);
    localparam int UW = $clog2(OUT_DEPTH + 1);

    logic           f_wr_en, mid_full, mid_empty, issue;
    cau_pkg::work_t f_wr_data, mid_data;
    logic           b_vld, out_full;
    cau_pkg::rsp_t  b_rsp;
    logic [UW-1:0]  used_reg, used_next;
    logic           pop_ok;

    cau_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .cmd     (cmd),
        .full    (full),
        .wr_en   (f_wr_en),
        .wr_data (f_wr_data),
        .wr_full (mid_full)
    );

    cau_fifo #(
        .WIDTH ($bits(cau_pkg::work_t)),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (f_wr_en),
        .wr_data (f_wr_data),
        .full    (mid_full),
        .rd_en   (issue),
        .rd_data (mid_data),
        .empty   (mid_empty)
    );

    // Issue only against a reserved result slot
    assign issue  = !mid_empty && (used_reg < UW'(OUT_DEPTH));
    assign pop_ok = pop && !empty;

    always_comb
    begin
        used_next = used_reg;
        if (issue && !pop_ok)
        begin
            used_next = used_reg + 1'b1;
        end else if (pop_ok && !issue)
        begin
            used_next = used_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
        end else
        begin
            used_reg <= used_next;
        end
    end

    cau_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (issue),
        .in_work (mid_data),
        .out_vld (b_vld),
        .out_rsp (b_rsp)
    );

    cau_fifo #(
        .WIDTH ($bits(cau_pkg::rsp_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (b_vld),
        .wr_data (b_rsp),
        .full    (out_full),
        .rd_en   (pop),
        .rd_data (rsp),
        .empty   (empty)
    );

    `CAU_ASSERT_ALWAYS(a_used_bound, clk, rst_n, used_reg <= UW'(OUT_DEPTH), "slot count overrun")
    `CAU_ASSERT_IMPL(a_no_drop, clk, rst_n, b_vld, !out_full, "result lost on full queue")
    `CAU_ASSERT_IMPL(a_dz_zero, clk, rst_n, !empty && rsp.div_zero,
        rsp.res_re == 16'sd0 && rsp.res_im == 16'sd0 && !rsp.saturated, "bad zero-divisor beat")
endmodule

// ===== bench/complex_arith_unit_tb.sv =====
// Self-checking bench for the complex arithmetic unit: random and directed beats.
`timescale 1ns / 1ps
module complex_arith_unit_tb;

    logic           clk;
    logic           rst_n;
    logic           push;
    cau_pkg::cmd_t  cmd;
    logic           full;
    logic           pop;
    cau_pkg::rsp_t  rsp;
    logic           empty;

    complex_arith_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .cmd   (cmd),
        .full  (full),
        .pop   (pop),
        .rsp   (rsp),
        .empty (empty)
    );

    cau_pkg::cmd_t  cmd_backlog[$];
    cau_pkg::rsp_t  result_fifo[$];
    int    err_cnt;
    bit    feed_done;
    bit    drain_hold;   // request from stimulus: stop popping for a while
    bit    feed_pause;   // request from stimulus: wait for every result

    // Clip to Q8.8 and note whether clipping happened
    function automatic logic signed [15:0] clip_q88(input longint v, inout bit hit);
        if (v > 32767) begin
            hit = 1'b1;
            return 16'sh7fff;
        end
        if (v < -32768) begin
            hit = 1'b1;
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    // Expected result of one command
    function automatic cau_pkg::rsp_t complex_result(input cau_pkg::cmd_t c);
        longint ar, ai, br, bi, re, im, mag;
        bit     hit;
        cau_pkg::rsp_t r;
        ar = c.a_re; ai = c.a_im; br = c.b_re; bi = c.b_im;
        re = 0; im = 0; hit = 1'b0;
        r.div_zero = 1'b0;
        case (cau_pkg::op_e'(c.opcode))
            cau_pkg::OP_ADD: begin re = ar + br; im = ai + bi; end
            cau_pkg::OP_SUB: begin re = ar - br; im = ai - bi; end
            cau_pkg::OP_MUL: begin
                re = (ar * br - ai * bi) / 256;
                im = (ar * bi + ai * br) / 256;
            end
            default: begin
                mag = br * br + bi * bi;
                if (mag == 0) begin
                    r.div_zero = 1'b1;
                end else begin
                    re = ((ar * br + ai * bi) * 256) / mag;
                    im = ((ai * br - ar * bi) * 256) / mag;
                end
            end
        endcase
        r.res_re = clip_q88(re, hit);
        r.res_im = clip_q88(im, hit);
        r.saturated = hit;
        return r;
    endfunction

    function automatic logic signed [15:0] rand_operand();
        case ($urandom_range(0, 5))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'(int'($urandom_range(0, 1023)) - 512);
            3: return 16'sh0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic cau_pkg::cmd_t make_cmd(input cau_pkg::op_e op,
                                               input logic signed [15:0] ar,
                                               input logic signed [15:0] ai,
                                               input logic signed [15:0] br,
                                               input logic signed [15:0] bi);
        cau_pkg::cmd_t c;
        c.opcode = op; c.a_re = ar; c.a_im = ai; c.b_re = br; c.b_im = bi;
        return c;
    endfunction

    // Clock and reset
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Stimulus
    initial
    begin
        cau_pkg::op_e ops[4];
        cau_pkg::cmd_t c;
        ops = '{cau_pkg::OP_ADD, cau_pkg::OP_SUB, cau_pkg::OP_MUL, cau_pkg::OP_DIV};
        err_cnt = 0; feed_done = 0; drain_hold = 0; feed_pause = 0;
        foreach (ops[k])
        begin
            cmd_backlog.push_back(make_cmd(ops[k], 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff));
            cmd_backlog.push_back(make_cmd(ops[k], 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000));
            cmd_backlog.push_back(make_cmd(ops[k], 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000));
            cmd_backlog.push_back(make_cmd(ops[k], 16'sh0100, 16'sh0080, 16'shff00, 16'sh0001));
        end
        // zero divisor, tiny divisor, negative truncation
        cmd_backlog.push_back(make_cmd(cau_pkg::OP_DIV, 16'sh1234, 16'sh8000, 16'sh0000,
                                       16'sh0000));
        cmd_backlog.push_back(make_cmd(cau_pkg::OP_DIV, 16'sh0000, 16'sh0000, 16'sh0000,
                                       16'sh0000));
        cmd_backlog.push_back(make_cmd(cau_pkg::OP_DIV, 16'sh0001, 16'sh0000, 16'sh0000,
                                       16'sh0001));
        cmd_backlog.push_back(make_cmd(cau_pkg::OP_MUL, 16'shffff, 16'sh0000, 16'sh0001,
                                       16'sh0000));
        cmd_backlog.push_back(make_cmd(cau_pkg::OP_DIV, 16'shffff, 16'sh0001, 16'sh0003,
                                       16'sh0000));

        // Random part; long receiver hold-off and a full drain in the middle
        for (int n = 0; n < 700; n++)
        begin
            if (n == 200) drain_hold = 1'b1;
            if (n == 450) feed_pause = 1'b1;
            c = make_cmd(cau_pkg::op_e'($urandom_range(0, 3)), rand_operand(), rand_operand(),
                         rand_operand(), rand_operand());
            if (c.opcode == cau_pkg::OP_DIV && $urandom_range(0, 15) == 0)
            begin
                c.b_re = 16'sh0000; c.b_im = 16'sh0000;
            end
            cmd_backlog.push_back(c);
            while (cmd_backlog.size() > 8) @(posedge clk);
        end
        while (cmd_backlog.size() != 0) @(posedge clk);
        feed_done = 1'b1;
    end

    // Driver
    int gap_left;
    always @(posedge clk or negedge rst_n)
    begin
        int gap;
        if (!rst_n)
        begin
            push <= 1'b0;
            cmd  <= '0;
            gap_left <= 0;
        end else begin
            gap = gap_left;
            if (push && !full)
            begin
                result_fifo.push_back(complex_result(cmd));
                void'(cmd_backlog.pop_front());
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
            end
            if (push && full)
            begin
                // beat waits unchanged until taken
                push <= 1'b1;
            end else if (feed_pause) begin
                push <= 1'b0;
                gap_left <= gap;
                if (result_fifo.size() == 0) feed_pause <= 1'b0;
            end else if (gap > 0) begin
                push <= 1'b0;
                gap_left <= gap - 1;
            end else if (cmd_backlog.size() > 0) begin
                push <= 1'b1;
                cmd  <= cmd_backlog[0];
                gap_left <= 0;
            end else begin
                push <= 1'b0;
                gap_left <= 0;
            end
        end
    end

    // Monitor and receiver
    int stall_left;
    int hold_left;
    always @(posedge clk or negedge rst_n)
    begin
        cau_pkg::rsp_t want;
        int stall;
        if (!rst_n)
        begin
            pop <= 1'b0;
            stall_left <= 0;
            hold_left <= 0;
        end else begin
            stall = stall_left;
            if (pop && !empty)
            begin
                if (result_fifo.size() == 0)
                begin
                    $display("%0t: unexpected result beat, actual %h", $time, rsp);
                    err_cnt++;
                end else begin
                    want = result_fifo.pop_front();
                    if (rsp.res_re !== want.res_re)
                        $display("%0t: res_re expected %h actual %h", $time, want.res_re,
                                 rsp.res_re);
                    if (rsp.res_im !== want.res_im)
                        $display("%0t: res_im expected %h actual %h", $time, want.res_im,
                                 rsp.res_im);
                    if (rsp.saturated !== want.saturated)
                        $display("%0t: saturated expected %b actual %b", $time,
                                 want.saturated, rsp.saturated);
                    if (rsp.div_zero !== want.div_zero)
                        $display("%0t: div_zero expected %b actual %b", $time,
                                 want.div_zero, rsp.div_zero);
                    if (rsp !== want) err_cnt++;
                end
                stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
            end
            if (drain_hold && hold_left == 0)
            begin
                hold_left <= 300;
                drain_hold <= 1'b0;
                pop <= 1'b0;
                stall_left <= stall;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                pop <= 1'b0;
                stall_left <= stall;
            end else if (pop && empty) begin
                pop <= 1'b1;
                stall_left <= stall;
            end else if (stall > 0) begin
                pop <= 1'b0;
                stall_left <= stall - 1;
            end else begin
                pop <= 1'b1;
                stall_left <= 0;
            end
        end
    end

    // End of run
    initial
    begin
        wait (feed_done);
        while (result_fifo.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (err_cnt == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
